FILE: rtl/line_pixel_generator_defines.svh
// Assertion macros used by the checker file.
`ifndef LINE_PIXEL_GENERATOR_DEFINES_SVH
`define LINE_PIXEL_GENERATOR_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define LPG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("line pixel generator check failed");

// Next-cycle implication, masked during reset.
`define LPG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("line pixel generator check failed");

`endif

FILE: rtl/lpg_pkg.sv
package lpg_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int CFG_BITS       = 12;

    localparam logic [CFG_BITS-1:0] SCREEN_WIDTH_RST  = 12'd640;
    localparam logic [CFG_BITS-1:0] SCREEN_HEIGHT_RST = 12'd480;

    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_STEP = 1'b1
    } t_req;

    typedef enum logic {
        CFG_SCREEN_WIDTH  = 1'b0,
        CFG_SCREEN_HEIGHT = 1'b1
    } t_cfg_reg;

endpackage

FILE: rtl/line_pixel_generator.sv
// Channel   Direction  Handshake                   Payload
// in        sink       i_in_valid / o_in_ready     i_req_type, endpoints, colour
// out       source     o_out_valid / i_out_ready   pixel x/y, colour, on_screen, last
// cfg       sink       i_cfg_we                    i_cfg_addr, i_cfg_wdata
//
// One item per cycle while o_in_ready is high. A step item's pixel is registered
// in the output register, or in the skid entry if the output stalls; the path is
// one add on the error term and the screen compares. A load item gives no pixel
// and takes effect for the very next step item. i_rst_n is synchronous, active
// low; it drops any line and any pending pixel and sets the screen to 640 x 480.
// An output register plus one skid entry sit behind the state; o_in_ready
// falls only when both hold a pixel that the sink has not taken.
module line_pixel_generator #(
    parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // item input
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_req_type,
    input  logic signed [COORD_BITS-1:0]   i_start_x,
    input  logic signed [COORD_BITS-1:0]   i_start_y,
    input  logic signed [COORD_BITS-1:0]   i_end_x,
    input  logic signed [COORD_BITS-1:0]   i_end_y,
    input  logic [7:0]                     i_red_in,
    input  logic [7:0]                     i_green_in,
    input  logic [7:0]                     i_blue_in,
    // pixel output
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [COORD_BITS-1:0]   o_pixel_x,
    output logic signed [COORD_BITS-1:0]   o_pixel_y,
    output logic [7:0]                     o_red_out,
    output logic [7:0]                     o_green_out,
    output logic [7:0]                     o_blue_out,
    output logic                           o_on_screen,
    output logic                           o_last_pixel,
    // configuration writes
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_addr,
    input  logic [lpg_pkg::CFG_BITS-1:0]   i_cfg_wdata
);

    // Widths of the Bresenham terms:
    //   span / major / minor : COORD_BITS unsigned
    //   pixel counter        : COORD_BITS+1 (holds major+1)
    //   2*minor, 2*minor-2*major : COORD_BITS+2 signed
    //   error term           : COORD_BITS+3 signed, stays within +/- 2*major
    localparam int CW   = COORD_BITS;
    localparam int PLW  = CW + 1;
    localparam int ADDW = CW + 2;
    localparam int ERRW = CW + 3;
    localparam int CMPW = (CW > lpg_pkg::CFG_BITS) ? CW : lpg_pkg::CFG_BITS;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [lpg_pkg::CFG_BITS-1:0] r_screen_width;
    logic [lpg_pkg::CFG_BITS-1:0] r_screen_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width  <= lpg_pkg::SCREEN_WIDTH_RST;
            r_screen_height <= lpg_pkg::SCREEN_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (lpg_pkg::t_cfg_reg'(i_cfg_addr))
                lpg_pkg::CFG_SCREEN_WIDTH:  r_screen_width  <= i_cfg_wdata;
                lpg_pkg::CFG_SCREEN_HEIGHT: r_screen_height <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Line state
    // ------------------------------------------------------------------
    logic [CW-1:0]   r_cur_x, n_cur_x;
    logic [CW-1:0]   r_cur_y, n_cur_y;
    logic [ERRW-1:0] r_error, n_error;
    logic [ADDW-1:0] r_straight_add, n_straight_add;
    logic [ADDW-1:0] r_diagonal_add, n_diagonal_add;
    logic [PLW-1:0]  r_pixels_left, n_pixels_left;
    logic            r_x_negative, n_x_negative;
    logic            r_y_negative, n_y_negative;
    logic            r_x_major, n_x_major;
    logic [23:0]     r_colour, n_colour;
    logic            r_line_active, n_line_active;

    // Output register and skid entry
    logic            r_out_valid;
    logic            r_skid_valid;
    logic [CW-1:0]   r_out_x, r_out_y, r_skid_x, r_skid_y;
    logic [23:0]     r_out_colour, r_skid_colour;
    logic            r_out_on, r_out_last, r_skid_on, r_skid_last;

    logic in_fire;
    logic is_load;
    logic is_step;

    assign o_in_ready = !r_skid_valid;
    assign in_fire    = i_in_valid && o_in_ready;
    assign is_load    = in_fire && (lpg_pkg::t_req'(i_req_type) == lpg_pkg::REQ_LOAD);
    assign is_step    = in_fire && (lpg_pkg::t_req'(i_req_type) == lpg_pkg::REQ_STEP);

    // ------------------------------------------------------------------
    // Load setup: spans, axis choice and the initial error
    // ------------------------------------------------------------------
    logic signed [CW:0]  diff_x, diff_y;
    logic [CW:0]         abs_x, abs_y;
    logic [CW-1:0]       span_x, span_y;
    logic                ld_x_neg, ld_y_neg, ld_x_major;
    logic [CW-1:0]       major, minor;
    logic [ADDW-1:0]     ld_straight, ld_diagonal;
    logic [ERRW-1:0]     ld_error;

    always_comb begin
        diff_x      = {i_end_x[CW-1], i_end_x} - {i_start_x[CW-1], i_start_x};
        diff_y      = {i_end_y[CW-1], i_end_y} - {i_start_y[CW-1], i_start_y};
        ld_x_neg    = i_start_x > i_end_x;
        ld_y_neg    = i_start_y > i_end_y;
        abs_x       = ld_x_neg ? -diff_x : diff_x;
        abs_y       = ld_y_neg ? -diff_y : diff_y;
        span_x      = abs_x[CW-1:0];
        span_y      = abs_y[CW-1:0];
        ld_x_major  = span_x >= span_y;
        major       = ld_x_major ? span_x : span_y;
        minor       = ld_x_major ? span_y : span_x;
        ld_straight = {1'b0, minor, 1'b0};
        ld_diagonal = ld_straight - {1'b0, major, 1'b0};
        ld_error    = {1'b0, ld_straight} - ERRW'(major);
    end

    // ------------------------------------------------------------------
    // Step: emit the current pixel, then advance
    // ------------------------------------------------------------------
    logic            res_valid;
    logic            res_last;
    logic            res_on;
    logic            go_diag;
    logic            move_x, move_y;
    logic [ADDW-1:0] err_add;

    always_comb begin
        res_valid = is_step && r_line_active;
        res_last  = r_pixels_left <= PLW'(1);
        res_on    = !r_cur_x[CW-1] && !r_cur_y[CW-1]
                 && (CMPW'(r_cur_x) < CMPW'(r_screen_width))
                 && (CMPW'(r_cur_y) < CMPW'(r_screen_height));
        go_diag   = !r_error[ERRW-1] && (r_error != '0);
        move_x    = go_diag || r_x_major;
        move_y    = go_diag || !r_x_major;
        err_add   = go_diag ? r_diagonal_add : r_straight_add;
    end

    always_comb begin
        n_cur_x        = r_cur_x;
        n_cur_y        = r_cur_y;
        n_error        = r_error;
        n_straight_add = r_straight_add;
        n_diagonal_add = r_diagonal_add;
        n_pixels_left  = r_pixels_left;
        n_x_negative   = r_x_negative;
        n_y_negative   = r_y_negative;
        n_x_major      = r_x_major;
        n_colour       = r_colour;
        n_line_active  = r_line_active;
        if (is_load) begin
            // replace any line in progress
            n_cur_x        = i_start_x;
            n_cur_y        = i_start_y;
            n_error        = ld_error;
            n_straight_add = ld_straight;
            n_diagonal_add = ld_diagonal;
            n_pixels_left  = {1'b0, major} + PLW'(1);
            n_x_negative   = ld_x_neg;
            n_y_negative   = ld_y_neg;
            n_x_major      = ld_x_major;
            n_colour       = {i_red_in, i_green_in, i_blue_in};
            n_line_active  = 1'b1;
        end else if (res_valid) begin
            // adding all ones steps back by one
            if (move_x) begin
                n_cur_x = r_cur_x + (r_x_negative ? {CW{1'b1}} : CW'(1));
            end
            if (move_y) begin
                n_cur_y = r_cur_y + (r_y_negative ? {CW{1'b1}} : CW'(1));
            end
            n_error = r_error + {{(ERRW-ADDW){err_add[ADDW-1]}}, err_add};
            if (res_last) begin
                n_pixels_left = '0;
                n_line_active = 1'b0;
            end else begin
                n_pixels_left = r_pixels_left - PLW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_active <= 1'b0;
        end else begin
            r_line_active <= n_line_active;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_x        <= n_cur_x;
        r_cur_y        <= n_cur_y;
        r_error        <= n_error;
        r_straight_add <= n_straight_add;
        r_diagonal_add <= n_diagonal_add;
        r_pixels_left  <= n_pixels_left;
        r_x_negative   <= n_x_negative;
        r_y_negative   <= n_y_negative;
        r_x_major      <= n_x_major;
        r_colour       <= n_colour;
    end

    // ------------------------------------------------------------------
    // Output register with skid entry
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // no item enters; drain the skid entry into the output
            if (i_out_ready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (res_valid) begin
            if (!r_out_valid || i_out_ready) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (i_out_ready) begin
                r_out_x      <= r_skid_x;
                r_out_y      <= r_skid_y;
                r_out_colour <= r_skid_colour;
                r_out_on     <= r_skid_on;
                r_out_last   <= r_skid_last;
            end
        end else if (res_valid) begin
            if (!r_out_valid || i_out_ready) begin
                r_out_x      <= r_cur_x;
                r_out_y      <= r_cur_y;
                r_out_colour <= r_colour;
                r_out_on     <= res_on;
                r_out_last   <= res_last;
            end else begin
                r_skid_x      <= r_cur_x;
                r_skid_y      <= r_cur_y;
                r_skid_colour <= r_colour;
                r_skid_on     <= res_on;
                r_skid_last   <= res_last;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pixel_x    = r_out_x;
    assign o_pixel_y    = r_out_y;
    assign o_red_out    = r_out_colour[23:16];
    assign o_green_out  = r_out_colour[15:8];
    assign o_blue_out   = r_out_colour[7:0];
    assign o_on_screen  = r_out_on;
    assign o_last_pixel = r_out_last;

endmodule

FILE: rtl/lpg_checker.sv
`include "line_pixel_generator_defines.svh"

module lpg_checker #(
    parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic                  i_req_type,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic [COORD_BITS-1:0] o_pixel_x,
    input logic [COORD_BITS-1:0] o_pixel_y,
    input logic                  o_last_pixel
);

    logic load_fire;
    assign load_fire = i_in_valid && o_in_ready
                    && (lpg_pkg::t_req'(i_req_type) == lpg_pkg::REQ_LOAD);

    // hold a stalled pixel
    `LPG_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_pixel_x) && $stable(o_pixel_y) && $stable(o_last_pixel))

    // reset leaves no pixel pending
    `LPG_ASSERT_NOW(a_reset_empty, $past(!i_rst_n), !o_out_valid)

    // input stalls only while both output slots are full
    `LPG_ASSERT_NOW(a_stall_needs_full, !o_in_ready, o_out_valid)

    // a load never produces a pixel
    `LPG_ASSERT_NEXT(a_load_silent, load_fire && !o_out_valid, !o_out_valid)

endmodule

bind line_pixel_generator lpg_checker #(
    .COORD_BITS (COORD_BITS)
) u_lpg_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .i_req_type   (i_req_type),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_pixel_x    (o_pixel_x),
    .o_pixel_y    (o_pixel_y),
    .o_last_pixel (o_last_pixel)
);
